/* rtl/i2c_master_event_sequencer_top_assert.svh */
// Assertion macros for the I2C master event sequencer checker.
// Both take a label, a property expression and a message string.
`ifndef I2C_MASTER_EVENT_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_EVENT_SEQUENCER_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define I2CMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define I2CMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and constants shared by the I2C master event sequencer modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Transmit store depth and receive count ceiling
  localparam int TX_DEPTH  = 16;
  localparam int RX_MAX    = 255;
  localparam int TX_IDX_W  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int TX_CNT_W  = 5;
  localparam int RX_CNT_W  = 8;

  // Operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Interrupt control codes
  localparam logic [1:0] IRQ_KEEP    = 2'd0;
  localparam logic [1:0] IRQ_ENABLE  = 2'd1;
  localparam logic [1:0] IRQ_DISABLE = 2'd2;

  // Event flag bit positions
  localparam int EV_START_SENT = 0;
  localparam int EV_ADDR_SENT  = 1;
  localparam int EV_BYTE_DONE  = 2;
  localparam int EV_RX_FULL    = 3;
  localparam int EV_TX_EMPTY   = 4;

  // Errors that also request a stop: bus error and ack failure
  localparam logic [3:0] ERR_STOP_MASK = 4'b0101;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] slave_address;
    logic [4:0] tx_count;
    logic [7:0] rx_count;
    logic [3:0] tx_slot;
    logic [7:0] tx_byte;
    logic [4:0] event_flags;
    logic [3:0] error_flags;
    logic       transmitter_mode;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    logic       data_write_valid;
    logic [7:0] data_write_byte;
    logic       request_start;
    logic       request_stop;
    logic       clear_acknowledge;
    logic [1:0] interrupt_control;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       transfer_done;
    logic       transfer_failed;
    logic [3:0] error_mask;
  } result_t;

endpackage

/* rtl/i2c_master_event_sequencer_top.sv */
// ----------------------------------------------------------------------------
// i2c_master_event_sequencer_top
// I2C master transfer sequencer: one result transaction per item transaction.
//
// Usage:
//   item channel   - item_valid / item_stall / item (i2cms_pkg::item_t).
//                    Load transmit bytes, then a start item, then feed each
//                    controller event as it arrives.
//   result channel - result_valid / result_stall / result
//                    (i2cms_pkg::result_t), one result per item, in order.
//   The item sits in the input register while the decision logic works on
//   it, and the edge that takes it on loads the result register and updates
//   the transfer state. Throughput is one item per cycle while result_stall
//   is low; the decision logic and the state update complete as each item
//   is taken, so each item sees the state left by the one before it.
//   Reset (rst, synchronous) empties both registers and clears address,
//   counts, positions and phase; the transmit store keeps its contents.
//   While result_stall is high the result holds; one more item can be
//   taken into the input register, after which item_stall goes high.
// ----------------------------------------------------------------------------
module i2c_master_event_sequencer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  i2cms_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output i2cms_pkg::result_t  result
);

  logic               held_valid;
  i2cms_pkg::item_t   held;
  i2cms_pkg::result_t res;
  logic               free;
  logic               take;

  // a held item moves on when the result register has room
  assign take = held_valid && free;

  i2cms_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  i2cms_seq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .held (held),
    .res  (res)
  );

  i2cms_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .res          (res),
    .free         (free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* rtl/i2cms_in_stage.sv */
// ----------------------------------------------------------------------------
// i2cms_in_stage
// Input register: holds one accepted item until the sequencer takes it.
// ----------------------------------------------------------------------------
module i2cms_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  i2cms_pkg::item_t  item,
  input  logic              take,
  output logic              held_valid,
  output i2cms_pkg::item_t  held
);

  // stall only while a held item cannot move on
  assign item_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held <= item;
    end
  end

endmodule

/* rtl/i2cms_seq_core.sv */
// ----------------------------------------------------------------------------
// i2cms_seq_core
// Transfer state, transmit store and the per-item decision logic.
// ----------------------------------------------------------------------------
module i2cms_seq_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  i2cms_pkg::item_t    held,
  output i2cms_pkg::result_t  res
);

  logic [7:0]                        address_byte, address_byte_next;
  logic [i2cms_pkg::TX_CNT_W-1:0]    tx_total, tx_total_next;
  logic [i2cms_pkg::TX_CNT_W-1:0]    tx_position, tx_position_next;
  logic [i2cms_pkg::RX_CNT_W-1:0]    rx_total, rx_total_next;
  logic [i2cms_pkg::RX_CNT_W-1:0]    rx_position, rx_position_next;
  logic                              read_phase, read_phase_next;
  logic [7:0]                        tx_store [i2cms_pkg::TX_DEPTH];

  logic [i2cms_pkg::TX_IDX_W-1:0]    tx_idx;
  logic [7:0]                        tx_word;
  logic                              tx_left;
  logic [i2cms_pkg::TX_CNT_W-1:0]    tc_sat;
  logic [i2cms_pkg::RX_CNT_W-1:0]    rc_sat;
  logic [i2cms_pkg::RX_CNT_W-1:0]    rx_after;
  logic                              store_we;

  // position stays below total whenever a byte is sent, so index is in range
  assign tx_idx  = i2cms_pkg::TX_IDX_W'(tx_position);
  assign tx_word = tx_store[tx_idx];
  assign tx_left = tx_position < tx_total;

  // saturated counts for a start item
  assign tc_sat = (32'(held.tx_count) > i2cms_pkg::TX_DEPTH) ?
                  i2cms_pkg::TX_CNT_W'(i2cms_pkg::TX_DEPTH) : held.tx_count;
  assign rc_sat = (32'(held.rx_count) > i2cms_pkg::RX_MAX) ?
                  i2cms_pkg::RX_CNT_W'(i2cms_pkg::RX_MAX) : held.rx_count;

  // receive position after a receive event
  assign rx_after = (rx_position < rx_total) ? rx_position + 1'b1 : rx_position;

  assign store_we = take && (held.operation == i2cms_pkg::OP_LOAD) &&
                    (32'(held.tx_slot) < i2cms_pkg::TX_DEPTH);

  // decision logic
  always_comb begin
    res               = '0;
    address_byte_next = address_byte;
    tx_total_next     = tx_total;
    tx_position_next  = tx_position;
    rx_total_next     = rx_total;
    rx_position_next  = rx_position;
    read_phase_next   = read_phase;
    case (held.operation)
      i2cms_pkg::OP_LOAD: begin
        // store write handled in the clocked block
      end
      i2cms_pkg::OP_START: begin
        tx_total_next     = tc_sat;
        rx_total_next     = rc_sat;
        tx_position_next  = '0;
        rx_position_next  = '0;
        read_phase_next   = (tc_sat == '0);
        address_byte_next = {held.slave_address, (tc_sat == '0)};
        res.request_start     = 1'b1;
        res.interrupt_control = i2cms_pkg::IRQ_ENABLE;
      end
      i2cms_pkg::OP_EVENT: begin
        if (held.error_flags != '0) begin
          // abort: report and disable sources, state kept
          res.error_mask        = held.error_flags;
          res.interrupt_control = i2cms_pkg::IRQ_DISABLE;
          res.request_stop      = |(held.error_flags & i2cms_pkg::ERR_STOP_MASK);
          res.transfer_failed   = 1'b1;
        end else if (held.event_flags[i2cms_pkg::EV_START_SENT]) begin
          res.data_write_valid = 1'b1;
          res.data_write_byte  = address_byte;
        end else if (held.event_flags[i2cms_pkg::EV_ADDR_SENT]) begin
          if (held.transmitter_mode) begin
            if (tx_left) begin
              res.data_write_valid = 1'b1;
              res.data_write_byte  = tx_word;
              tx_position_next     = tx_position + 1'b1;
            end
          end else if (rx_total == 8'd1) begin
            res.clear_acknowledge = 1'b1;
            res.request_stop      = 1'b1;
          end
        end else if (held.event_flags[i2cms_pkg::EV_RX_FULL] && read_phase) begin
          if (rx_position < rx_total) begin
            res.rx_valid = 1'b1;
            res.rx_byte  = held.received_byte;
          end
          rx_position_next = rx_after;
          if (rx_after >= rx_total) begin
            res.interrupt_control = i2cms_pkg::IRQ_DISABLE;
            res.transfer_done     = 1'b1;
          end else if (rx_after == rx_total - 1'b1) begin
            res.clear_acknowledge = 1'b1;
            res.request_stop      = 1'b1;
          end
        end else if (held.event_flags[i2cms_pkg::EV_TX_EMPTY] && !read_phase && tx_left) begin
          res.data_write_valid = 1'b1;
          res.data_write_byte  = tx_word;
          tx_position_next     = tx_position + 1'b1;
        end else if (held.event_flags[i2cms_pkg::EV_BYTE_DONE] && !read_phase) begin
          if (tx_left) begin
            res.data_write_valid = 1'b1;
            res.data_write_byte  = tx_word;
            tx_position_next     = tx_position + 1'b1;
          end else if (rx_total != '0) begin
            // repeated start for the read part
            read_phase_next   = 1'b1;
            address_byte_next = address_byte | 8'd1;
            res.request_start = 1'b1;
          end else begin
            res.request_stop      = 1'b1;
            res.interrupt_control = i2cms_pkg::IRQ_DISABLE;
            res.transfer_done     = 1'b1;
          end
        end
      end
      default: begin
        // unknown operation: all-zero result
      end
    endcase
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= '0;
      tx_total     <= '0;
      tx_position  <= '0;
      rx_total     <= '0;
      rx_position  <= '0;
      read_phase   <= 1'b0;
    end else if (take) begin
      address_byte <= address_byte_next;
      tx_total     <= tx_total_next;
      tx_position  <= tx_position_next;
      rx_total     <= rx_total_next;
      rx_position  <= rx_position_next;
      read_phase   <= read_phase_next;
    end
  end

  // transmit store, undefined until written
  always_ff @(posedge clk) begin
    if (store_we) begin
      tx_store[i2cms_pkg::TX_IDX_W'(held.tx_slot)] <= held.tx_byte;
    end
  end

endmodule

/* rtl/i2cms_out_stage.sv */
// ----------------------------------------------------------------------------
// i2cms_out_stage
// Result register: holds a result until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cms_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  i2cms_pkg::result_t  res,
  output logic                free,
  output logic                result_valid,
  input  logic                result_stall,
  output i2cms_pkg::result_t  result
);

  // room for a new result when empty or being drained this cycle
  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

endmodule

/* rtl/i2cms_checker.sv */
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks for the I2C master event sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "i2c_master_event_sequencer_top_assert.svh"

module i2cms_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_stall,
  input i2cms_pkg::result_t  result
);

  // no result right after reset
  `I2CMS_ASSERT_ALWAYS(a_rst_empty, rst |=> !result_valid, "result valid after reset")

  // stalled result holds
  `I2CMS_ASSERT(a_hold,
    result_valid && result_stall |=> result_valid && $stable(result),
    "stalled result changed")

  // a failure disables sources and is never also a completion
  `I2CMS_ASSERT(a_fail_irq,
    result_valid && result.transfer_failed |->
      result.interrupt_control == i2cms_pkg::IRQ_DISABLE && !result.transfer_done,
    "failure without disable")

  // error mask is reported exactly on failures
  `I2CMS_ASSERT(a_err_mask,
    result_valid |-> (result.error_mask != 4'd0) == result.transfer_failed,
    "error mask mismatch")

  // byte fields are zero without their valid bits
  `I2CMS_ASSERT(a_zero_bytes,
    result_valid && !result.data_write_valid && !result.rx_valid |->
      result.data_write_byte == 8'd0 && result.rx_byte == 8'd0,
    "byte field not zero")

endmodule

bind i2c_master_event_sequencer_top i2cms_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
